FILE: hdl/tnns_pkg.sv
// Shared types and constants for the tree nearest-node steering core.
`default_nettype none
package tnns_pkg;
    localparam int COST_BITS = 24;
    localparam int IDX_BITS  = 9;
    localparam logic [1:0] REQ_ROOT   = 2'd0;
    localparam logic [1:0] REQ_EXTEND = 2'd1;
    localparam logic [1:0] REQ_ACCEPT = 2'd2;
    localparam logic [COST_BITS-1:0] COST_MAX = '1;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_SCAN   = 11'b00000000010,
        ST_SQRT   = 11'b00000000100,
        ST_BEST   = 11'b00000001000,
        ST_RD     = 11'b00000010000,
        ST_RDW    = 11'b00000100000,
        ST_R15    = 11'b00001000000,
        ST_DIVX   = 11'b00010000000,
        ST_DIVY   = 11'b00100000000,
        ST_WRITE  = 11'b01000000000,
        ST_OUT    = 11'b10000000000
    } t_state;
endpackage
`default_nettype wire

FILE: hdl/tree_nearest_node_steer_core.sv
// Top level of the tree nearest-node steering core.
// Each request produces exactly one result transaction. The input stalls from
// acceptance until that result has been taken. A root request passes through
// the write and output states; an accept request of a tentative node passes a
// read state before them. An extend request reads every committed node from the
// node memory in turn, one per pass. Each pass is a read, a 2-bit-per-cycle
// integer square root and a compare. After the scan an unsteered node goes from
// a decision state to the write state. A steered node instead takes a square
// root of the scaled distance, a set-up step and two bit-serial divides, one per
// axis. The shared square-root unit and the serial divider set the rate.
// Node storage needs no clearing pass; committed slots are always written
// before they are read.
`default_nettype none
module tree_nearest_node_steer_core #(
    parameter int CAPACITY   = 512,
    parameter int COORD_BITS = 12
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire  [1:0]                   i_req_type,
    input  wire  [COORD_BITS-1:0]        i_sample_x,
    input  wire  [COORD_BITS-1:0]        i_sample_y,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [11:0]                  i_cfg_data,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [COORD_BITS-1:0]        o_node_x,
    output logic [COORD_BITS-1:0]        o_node_y,
    output logic [tnns_pkg::IDX_BITS-1:0] o_parent_index,
    output logic [tnns_pkg::COST_BITS-1:0] o_path_cost,
    output logic [tnns_pkg::IDX_BITS-1:0] o_slot_index,
    output logic                         o_was_steered
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DB = 2 * COORD_BITS + 2;     // squared distance
    localparam int SB = COORD_BITS + 1;         // distance
    localparam int RB = DB + 30;                // radicand for the fine root
    localparam int QB = 64;                     // divide width
    localparam int PB = COORD_BITS + 12;        // offset times step limit
    localparam int IW = tnns_pkg::IDX_BITS;
    localparam int KW = tnns_pkg::COST_BITS;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [KW-1:0]         cost;
        logic [AW-1:0]         parent;
    } t_word;

    // node memory, registered read
    t_word r_mem [CAPACITY];
    t_word r_rd;
    logic [AW-1:0] n_raddr;
    logic          n_we;
    logic [AW-1:0] n_waddr;
    t_word         n_wdata;

    always_ff @(posedge i_clk) begin
        if (n_we) r_mem[n_waddr] <= n_wdata;
        r_rd <= r_mem[n_raddr];
    end

    tnns_pkg::t_state r_st;
    logic [CW-1:0] r_count;
    logic          r_tent, r_tsteer;
    logic [11:0]   r_step;
    logic [1:0]    r_req;
    logic [COORD_BITS-1:0] r_sx, r_sy;
    logic [CW-1:0] r_idx;
    logic          r_have;
    logic [AW-1:0] r_best;
    logic [SB-1:0] r_bestd;
    logic [DB-1:0] r_bestD;
    t_word         r_node;
    t_word         r_bnode;
    // shared root unit
    logic [RB-1:0] r_rem, r_rad;
    logic [RB-1:0] r_res;
    logic [6:0]    r_cnt;
    logic [DB-1:0] r_curD;
    logic          r_tsteer_pass;
    // divider
    logic [QB-1:0] r_num, r_quo;
    logic [QB-1:0] r_drem;
    logic [RB-1:0] r_r15;
    logic          r_negx, r_negy;
    logic [PB-1:0] r_prody;
    logic [KW:0]   r_costsum;

    assign o_stall     = !(r_st == tnns_pkg::ST_IDLE) || o_valid;
    assign o_cfg_ready = 1'b1;

    // distances to the node being read
    logic signed [COORD_BITS+1:0] w_dx, w_dy;
    logic [DB-1:0] w_D;
    assign w_dx = $signed({2'b00, r_sx}) - $signed({2'b00, r_rd.x});
    assign w_dy = $signed({2'b00, r_sy}) - $signed({2'b00, r_rd.y});
    assign w_D  = DB'(w_dx * w_dx) + DB'(w_dy * w_dy);

    // one root step: two radicand bits per cycle
    logic [RB+1:0] w_trial;
    logic [RB+1:0] w_rem2;
    assign w_rem2  = {r_rem, r_rad[RB-1 -: 2]};
    assign w_trial = {r_res[RB-1:0], 2'b01};

    // per-axis offset magnitudes scaled by the step limit
    logic [COORD_BITS-1:0] w_magx, w_magy;
    logic [PB-1:0]         w_prodx, w_prody;
    assign w_magx  = (r_sx < r_bnode.x) ? r_bnode.x - r_sx : r_sx - r_bnode.x;
    assign w_magy  = (r_sy < r_bnode.y) ? r_bnode.y - r_sy : r_sy - r_bnode.y;
    assign w_prodx = PB'(w_magx) * PB'(r_step);
    assign w_prody = PB'(w_magy) * PB'(r_step);

    // one divide step: shift in a numerator bit, subtract when it fits
    logic [QB:0] w_drem2;
    assign w_drem2 = {r_drem, r_num[QB-1]};

    logic [COORD_BITS:0] w_off;
    logic [QB-1:0] w_qr;
    assign w_qr  = (r_quo + QB'(32768)) >> 16;
    assign w_off = w_qr[COORD_BITS:0];

    function automatic logic [COORD_BITS-1:0] apply(
        input logic [COORD_BITS-1:0] base, input logic neg,
        input logic [COORD_BITS:0] off);
        logic [COORD_BITS+1:0] s;
        begin
            if (neg) begin
                apply = (off > {1'b0, base}) ? '0 : base - off[COORD_BITS-1:0];
            end else begin
                s = {2'b00, base} + {1'b0, off};
                apply = (s > {2'b00, {COORD_BITS{1'b1}}}) ? '1 : s[COORD_BITS-1:0];
            end
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= tnns_pkg::ST_IDLE;
            r_count <= '0; r_tent <= 1'b0; r_tsteer <= 1'b0;
            r_tsteer_pass <= 1'b0;
            r_step <= 12'd3; o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_step <= i_cfg_data;
            if (o_valid && !i_stall) o_valid <= 1'b0;
            case (r_st)
                tnns_pkg::ST_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_req <= i_req_type; r_sx <= i_sample_x; r_sy <= i_sample_y;
                        r_idx <= '0; r_have <= 1'b0;
                        o_node_x <= '0; o_node_y <= '0; o_parent_index <= '0;
                        o_path_cost <= '0; o_slot_index <= '0; o_was_steered <= 1'b0;
                        case (i_req_type)
                            tnns_pkg::REQ_ROOT: r_st <= tnns_pkg::ST_WRITE;
                            tnns_pkg::REQ_EXTEND: r_st <= (r_count == '0) ?
                                tnns_pkg::ST_OUT : tnns_pkg::ST_SCAN;
                            tnns_pkg::REQ_ACCEPT: r_st <= r_tent ?
                                tnns_pkg::ST_RD : tnns_pkg::ST_OUT;
                            default: r_st <= tnns_pkg::ST_OUT;
                        endcase
                    end
                end
                tnns_pkg::ST_SCAN: begin
                    // read data for r_idx arrives now
                    r_node <= r_rd;
                    r_curD <= w_D;
                    r_rad <= RB'(w_D) << (RB - DB);
                    r_rem <= '0; r_res <= '0;
                    r_cnt <= 7'(DB / 2);
                    r_st <= tnns_pkg::ST_SQRT;
                end
                tnns_pkg::ST_SQRT: begin
                    if (w_rem2 >= w_trial) begin
                        r_rem <= RB'(w_rem2 - w_trial);
                        r_res <= {r_res[RB-2:0], 1'b1};
                    end else begin
                        r_rem <= RB'(w_rem2);
                        r_res <= {r_res[RB-2:0], 1'b0};
                    end
                    r_rad <= r_rad << 2;
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == 7'd1) r_st <= r_tsteer_pass ? tnns_pkg::ST_R15
                                                            : tnns_pkg::ST_BEST;
                end
                tnns_pkg::ST_BEST: begin
                    if (!r_have || SB'(r_res) < r_bestd) begin
                        r_have <= 1'b1; r_best <= r_idx[AW-1:0];
                        r_bestd <= SB'(r_res); r_bestD <= r_curD; r_bnode <= r_node;
                    end
                    r_idx <= r_idx + CW'(1);
                    r_st <= (r_idx + CW'(1) == r_count) ? tnns_pkg::ST_RDW
                                                        : tnns_pkg::ST_SCAN;
                end
                tnns_pkg::ST_RDW: begin
                    if (r_bestd > SB'(r_step)) begin
                        r_rad <= RB'(r_bestD) << 30;
                        r_rem <= '0; r_res <= '0;
                        r_cnt <= 7'(RB / 2);
                        r_tsteer_pass <= 1'b1;
                        r_st <= tnns_pkg::ST_SQRT;
                    end else begin
                        r_tsteer <= 1'b0;
                        r_node.x <= r_sx; r_node.y <= r_sy;
                        r_costsum <= {1'b0, r_bnode.cost} + (KW+1)'(r_bestd);
                        r_st <= tnns_pkg::ST_WRITE;
                    end
                end
                tnns_pkg::ST_R15: begin
                    // latch the fine root and set up the x divide
                    r_tsteer_pass <= 1'b0;
                    r_r15 <= r_res;
                    r_negx <= r_sx < r_bnode.x;
                    r_negy <= r_sy < r_bnode.y;
                    r_num <= QB'(w_prodx) << 31;
                    r_prody <= w_prody;
                    r_drem <= '0; r_cnt <= 7'd64;
                    r_st <= tnns_pkg::ST_DIVX;
                end
                tnns_pkg::ST_DIVX, tnns_pkg::ST_DIVY: begin
                    if (r_cnt != 7'd0) begin
                        if (w_drem2 >= (QB+1)'(r_r15)) begin
                            r_drem <= QB'(w_drem2 - (QB+1)'(r_r15));
                            r_quo <= {r_quo[QB-2:0], 1'b1};
                        end else begin
                            r_drem <= QB'(w_drem2);
                            r_quo <= {r_quo[QB-2:0], 1'b0};
                        end
                        r_num <= r_num << 1;
                        r_cnt <= r_cnt - 7'd1;
                    end else if (r_st == tnns_pkg::ST_DIVX) begin
                        r_node.x <= apply(r_bnode.x, r_negx, w_off);
                        r_num <= QB'(r_prody) << 31;
                        r_drem <= '0; r_cnt <= 7'd64;
                        r_st <= tnns_pkg::ST_DIVY;
                    end else begin
                        r_node.y <= apply(r_bnode.y, r_negy, w_off);
                        r_tsteer <= 1'b1;
                        r_costsum <= {1'b0, r_bnode.cost} + (KW+1)'(r_step);
                        r_st <= tnns_pkg::ST_WRITE;
                    end
                end
                tnns_pkg::ST_RD: begin
                    r_st <= tnns_pkg::ST_WRITE;
                end
                tnns_pkg::ST_WRITE: begin
                    case (r_req)
                        tnns_pkg::REQ_ROOT: begin
                            o_node_x <= r_sx; o_node_y <= r_sy;
                            o_slot_index <= '0;
                            r_count <= CW'(1); r_tent <= 1'b0; r_tsteer <= 1'b0;
                        end
                        tnns_pkg::REQ_EXTEND: begin
                            o_node_x <= r_node.x; o_node_y <= r_node.y;
                            o_parent_index <= IW'(r_best);
                            o_path_cost <= r_costsum[KW] ? tnns_pkg::COST_MAX
                                                         : r_costsum[KW-1:0];
                            o_slot_index <= IW'(r_count);
                            o_was_steered <= r_tsteer;
                            r_tent <= 1'b1;
                        end
                        default: begin
                            o_node_x <= r_rd.x; o_node_y <= r_rd.y;
                            o_parent_index <= IW'(r_rd.parent);
                            o_path_cost <= r_rd.cost;
                            o_slot_index <= IW'(r_count);
                            o_was_steered <= r_tsteer;
                            r_count <= (r_count + CW'(1) >= CW'(CAPACITY)) ? CW'(1)
                                                                      : r_count + CW'(1);
                            r_tent <= 1'b0; r_tsteer <= 1'b0;
                        end
                    endcase
                    r_st <= tnns_pkg::ST_OUT;
                end
                tnns_pkg::ST_OUT: begin
                    o_valid <= 1'b1;
                    r_st <= tnns_pkg::ST_IDLE;
                end
                default: r_st <= tnns_pkg::ST_IDLE;
            endcase
        end
    end

    // memory address and write control
    always_comb begin
        n_raddr = AW'(r_count);
        if (r_st == tnns_pkg::ST_IDLE) n_raddr = '0;
        if (r_st == tnns_pkg::ST_BEST) n_raddr = AW'(r_idx + CW'(1));
        n_we = 1'b0; n_waddr = AW'(r_count); n_wdata = r_node;
        if (r_st == tnns_pkg::ST_WRITE && r_req == tnns_pkg::REQ_ROOT) begin
            n_we = 1'b1; n_waddr = '0;
            n_wdata = '{x: r_sx, y: r_sy, cost: '0, parent: '0};
        end else if (r_st == tnns_pkg::ST_WRITE && r_req == tnns_pkg::REQ_EXTEND) begin
            n_we = 1'b1;
            n_wdata = '{x: r_node.x, y: r_node.y,
                        cost: r_costsum[KW] ? tnns_pkg::COST_MAX : r_costsum[KW-1:0],
                        parent: r_best};
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY)) else $error("count out of range");
    a_out_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> r_st == tnns_pkg::ST_IDLE) else $error("result outside idle");
    a_extend_needs_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == tnns_pkg::ST_SCAN |-> r_count != '0) else $error("scan without root");
`endif
endmodule
`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the tree nearest-node steering core.
`timescale 1ns / 100ps
`default_nettype none
module tb;

    localparam int CAPACITY   = 512;
    localparam int COORD_BITS = 12;
    localparam int CYCLE_LIMIT = 4000000;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]            req;
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
    } t_tree_request;

    typedef struct packed {
        logic [COORD_BITS-1:0]          nx;
        logic [COORD_BITS-1:0]          ny;
        logic [tnns_pkg::IDX_BITS-1:0]  parent;
        logic [tnns_pkg::COST_BITS-1:0] cost;
        logic [tnns_pkg::IDX_BITS-1:0]  slot;
        logic                           steered;
    } t_node_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [1:0]            i_req_type;
    logic [COORD_BITS-1:0] i_sample_x;
    logic [COORD_BITS-1:0] i_sample_y;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [11:0]           i_cfg_data;
    logic                  o_valid;
    logic                  i_stall;
    logic [COORD_BITS-1:0] o_node_x;
    logic [COORD_BITS-1:0] o_node_y;
    logic [tnns_pkg::IDX_BITS-1:0]  o_parent_index;
    logic [tnns_pkg::COST_BITS-1:0] o_path_cost;
    logic [tnns_pkg::IDX_BITS-1:0]  o_slot_index;
    logic                  o_was_steered;

    tree_nearest_node_steer_core #(
        .CAPACITY   (CAPACITY),
        .COORD_BITS (COORD_BITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_sample_x     (i_sample_x),
        .i_sample_y     (i_sample_y),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_node_x       (o_node_x),
        .o_node_y       (o_node_y),
        .o_parent_index (o_parent_index),
        .o_path_cost    (o_path_cost),
        .o_slot_index   (o_slot_index),
        .o_was_steered  (o_was_steered)
    );

    // Requests waiting to be driven, and results the tree should produce.
    t_tree_request pending_reqs[$];
    t_node_result  expected_nodes[$];
    int            err_cnt = 0;
    int            cycle_cnt = 0;

    // Predictor's own copy of the tree and the step limit.
    logic [COORD_BITS-1:0]          tree_x [CAPACITY];
    logic [COORD_BITS-1:0]          tree_y [CAPACITY];
    logic [tnns_pkg::COST_BITS-1:0] tree_cost [CAPACITY];
    logic [tnns_pkg::IDX_BITS-1:0]  tree_parent [CAPACITY];
    int                    committed_cnt = 0;
    logic                  tent_valid = 1'b0;
    logic                  tent_steered = 1'b0;
    logic [11:0]           step_lim = 12'd3;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint exp);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, exp, cycle_cnt);
        err_cnt++;
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Pull one axis back towards the parent: offset rounded half away from zero.
    function automatic logic [COORD_BITS-1:0] steer_axis(input int base, input int d,
                                                         input longint unsigned r15);
        longint unsigned mag;
        longint unsigned q;
        longint unsigned off;
        longint          v;
        mag = (d < 0) ? -d : d;
        q   = ((longint'(step_lim) * mag) << 31) / r15;
        off = (q + 32768) >> 16;
        if (d < 0) v = longint'(base) - longint'(off);
        else       v = longint'(base) + longint'(off);
        if (v < 0) v = 0;
        if (v > (1 << COORD_BITS) - 1) v = (1 << COORD_BITS) - 1;
        return v[COORD_BITS-1:0];
    endfunction

    function automatic void predict_node(input t_tree_request rq);
        t_node_result    r;
        int              best;
        longint unsigned bestd;
        longint unsigned bestsq;
        longint unsigned dsq;
        longint unsigned dist_val;
        longint unsigned cost;
        longint unsigned r15;
        int              dx;
        int              dy;
        int              slot;
        r = '0;
        case (rq.req)
            tnns_pkg::REQ_ROOT: begin
                tree_x[0] = rq.sx;
                tree_y[0] = rq.sy;
                tree_cost[0] = '0;
                tree_parent[0] = '0;
                committed_cnt = 1;
                tent_valid = 1'b0;
                tent_steered = 1'b0;
                r.nx = rq.sx;
                r.ny = rq.sy;
            end
            tnns_pkg::REQ_EXTEND: begin
                if (committed_cnt != 0 && committed_cnt < CAPACITY) begin
                    slot = committed_cnt;
                    best = 0;
                    bestd = 0;
                    bestsq = 0;
                    for (int i = 0; i < committed_cnt; i++) begin
                        dx = int'(rq.sx) - int'(tree_x[i]);
                        dy = int'(rq.sy) - int'(tree_y[i]);
                        dsq = longint'(dx * dx) + longint'(dy * dy);
                        dist_val = int_sqrt(dsq);
                        if (i == 0 || dist_val < bestd) begin
                            best = i;
                            bestd = dist_val;
                            bestsq = dsq;
                        end
                    end
                    if (bestd > step_lim) begin
                        r15 = int_sqrt(bestsq << 30);
                        r.nx = steer_axis(int'(tree_x[best]),
                                          int'(rq.sx) - int'(tree_x[best]), r15);
                        r.ny = steer_axis(int'(tree_y[best]),
                                          int'(rq.sy) - int'(tree_y[best]), r15);
                        cost = longint'(tree_cost[best]) + step_lim;
                        tent_steered = 1'b1;
                    end else begin
                        r.nx = rq.sx;
                        r.ny = rq.sy;
                        cost = longint'(tree_cost[best]) + bestd;
                        tent_steered = 1'b0;
                    end
                    if (cost > tnns_pkg::COST_MAX) cost = tnns_pkg::COST_MAX;
                    tree_x[slot] = r.nx;
                    tree_y[slot] = r.ny;
                    tree_cost[slot] = cost[tnns_pkg::COST_BITS-1:0];
                    tree_parent[slot] = best[tnns_pkg::IDX_BITS-1:0];
                    tent_valid = 1'b1;
                    r.parent = best[tnns_pkg::IDX_BITS-1:0];
                    r.cost = cost[tnns_pkg::COST_BITS-1:0];
                    r.slot = slot[tnns_pkg::IDX_BITS-1:0];
                    r.steered = tent_steered;
                end
            end
            tnns_pkg::REQ_ACCEPT: begin
                if (tent_valid && committed_cnt < CAPACITY) begin
                    slot = committed_cnt;
                    r.nx = tree_x[slot];
                    r.ny = tree_y[slot];
                    r.parent = tree_parent[slot];
                    r.cost = tree_cost[slot];
                    r.slot = slot[tnns_pkg::IDX_BITS-1:0];
                    r.steered = tent_steered;
                    committed_cnt++;
                    if (committed_cnt >= CAPACITY) committed_cnt = 1;
                    tent_valid = 1'b0;
                    tent_steered = 1'b0;
                end
            end
            default: ;
        endcase
        expected_nodes = {expected_nodes, r};
    endfunction

    // Driver: present queued requests in bursts separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_req_type <= tnns_pkg::REQ_ROOT;
            i_sample_x <= '0;
            i_sample_y <= '0;
        end else begin
            // Retire an accepted transaction and predict its result.
            if (i_valid && !o_stall) begin
                predict_node(pending_reqs.pop_front());
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end
            end
            // Hold a stalled payload; otherwise advance or idle.
            if (!(i_valid && o_stall)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    i_valid <= 1'b1;
                    i_req_type <= pending_reqs[0].req;
                    i_sample_x <= pending_reqs[0].sx;
                    i_sample_y <= pending_reqs[0].sy;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall on a pattern whose mode is chosen by bits 9:8 of the cycle count.
    always @(posedge i_clk) begin
        t_node_result e;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            case (cycle_cnt[9:8])
                2'd0:    i_stall <= 1'b0;
                2'd1:    i_stall <= ($urandom_range(0, 3) == 0);
                2'd2:    i_stall <= ($urandom_range(0, 3) != 0);
                default: i_stall <= cycle_cnt[2];
            endcase
            if (o_valid && !i_stall) begin
                if (expected_nodes.size() == 0) begin
                    report_mismatch("unexpected result", o_slot_index, 0);
                end else begin
                    e = expected_nodes.pop_front();
                    if (o_node_x !== e.nx) report_mismatch("node_x", o_node_x, e.nx);
                    if (o_node_y !== e.ny) report_mismatch("node_y", o_node_y, e.ny);
                    if (o_parent_index !== e.parent)
                        report_mismatch("parent_index", o_parent_index, e.parent);
                    if (o_path_cost !== e.cost) report_mismatch("path_cost", o_path_cost, e.cost);
                    if (o_slot_index !== e.slot) report_mismatch("slot_index", o_slot_index, e.slot);
                    if (o_was_steered !== e.steered)
                        report_mismatch("was_steered", o_was_steered, e.steered);
                end
            end
        end
    end

    // Watchdog: end the run if the core hangs.
    always @(posedge i_clk) begin
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic add_req(input logic [1:0] req, input int x, input int y);
        t_tree_request rq;
        rq.req = req;
        rq.sx = x[COORD_BITS-1:0];
        rq.sy = y[COORD_BITS-1:0];
        pending_reqs = {pending_reqs, rq};
    endtask

    function automatic int near_coord(input int base, input int spread);
        int v;
        v = base + $urandom_range(0, 2 * spread) - spread;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v;
    endfunction

    // Build well-formed trees with random content, plus some noise.
    task automatic add_random_trees(input int n_items);
        int made;
        int rx;
        int ry;
        int nodes;
        int spread;
        made = 0;
        while (made < n_items) begin
            rx = $urandom_range(0, 4095);
            ry = $urandom_range(0, 4095);
            add_req(tnns_pkg::REQ_ROOT, rx, ry);
            made++;
            nodes = $urandom_range(1, 24);
            spread = 1 << $urandom_range(1, 11);
            for (int k = 0; k < nodes && made < n_items; k++) begin
                case ($urandom_range(0, 15))
                    0: add_req(REQ_UNUSED, $urandom, $urandom);
                    1: add_req(tnns_pkg::REQ_ACCEPT, $urandom, $urandom);
                    2: add_req(tnns_pkg::REQ_EXTEND, $urandom_range(0, 4095),
                               $urandom_range(0, 4095));
                    default: add_req(tnns_pkg::REQ_EXTEND, near_coord(rx, spread),
                                     near_coord(ry, spread));
                endcase
                made++;
                if ($urandom_range(0, 4) != 0) begin
                    add_req(tnns_pkg::REQ_ACCEPT, $urandom, $urandom);
                    made++;
                end
            end
        end
    endtask

    task automatic write_step_limit(input logic [11:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        step_lim = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        wait (pending_reqs.size() == 0 && expected_nodes.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    initial begin
        logic [11:0] settings [6];
        settings = '{12'd1, 12'd4095, 12'd0, 12'd0, 12'd1000, 12'd3};
        settings[3] = 12'($urandom_range(2, 200));
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: requests before any root, extremes, replace and discard.
        add_req(tnns_pkg::REQ_EXTEND, 100, 100);
        add_req(tnns_pkg::REQ_ACCEPT, 0, 0);
        add_req(REQ_UNUSED, 4095, 4095);
        add_req(tnns_pkg::REQ_ROOT, 0, 0);
        add_req(tnns_pkg::REQ_ACCEPT, 0, 0);
        add_req(tnns_pkg::REQ_EXTEND, 1, 2);
        add_req(tnns_pkg::REQ_ACCEPT, 0, 0);
        add_req(tnns_pkg::REQ_EXTEND, 4095, 4095);
        add_req(tnns_pkg::REQ_EXTEND, 4095, 0);
        add_req(tnns_pkg::REQ_ACCEPT, 0, 0);
        add_req(tnns_pkg::REQ_EXTEND, 0, 4095);
        add_req(tnns_pkg::REQ_ROOT, 4095, 4095);
        add_req(tnns_pkg::REQ_ACCEPT, 0, 0);
        add_req(tnns_pkg::REQ_EXTEND, 0, 0);
        add_req(tnns_pkg::REQ_ACCEPT, 0, 0);
        add_req(tnns_pkg::REQ_EXTEND, 4094, 4095);
        add_req(tnns_pkg::REQ_ACCEPT, 0, 0);
        add_req(tnns_pkg::REQ_EXTEND, 4095, 4092);
        add_req(tnns_pkg::REQ_ACCEPT, 0, 0);
        add_req(REQ_UNUSED, 0, 0);
        add_req(tnns_pkg::REQ_ROOT, 2048, 2047);
        wait_idle();

        foreach (settings[s]) begin
            write_step_limit(settings[s]);
            add_random_trees(175);
            wait_idle();
        end

        if (err_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
